FILE: src/tlm_pkg.sv
// Package for the thread list manager: widths, codes, list numbers,
// controller states and commands, and the datapath status bundle.
// No dependencies.
package tlm_pkg;

	localparam int TLM_MAX_THREADS   = 64;
	localparam int TLM_MAX_PROCESSES = 64;

	localparam int NUM_LISTS = 7;
	localparam int LIST_W    = 3;
	localparam int SLOT_W    = 6;
	localparam int PROC_W    = 6;
	localparam int ID_W      = 32;
	localparam int TIME_W    = 32;
	localparam int FUNC_W    = 2;
	localparam int STAT_W    = 2;

	localparam logic [FUNC_W-1:0] FN_CREATE = 2'd0;
	localparam logic [FUNC_W-1:0] FN_MOVE   = 2'd1;
	localparam logic [FUNC_W-1:0] FN_FIND   = 2'd2;
	localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

	localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
	localparam logic [STAT_W-1:0] ST_ERROR    = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;

	localparam logic [1:0] TGT_WAITING = 2'd3;

	localparam logic [LIST_W-1:0] L_READY      = 3'd0;
	localparam logic [LIST_W-1:0] L_RUNNING    = 3'd1;
	localparam logic [LIST_W-1:0] L_TERMINATED = 3'd2;
	localparam logic [LIST_W-1:0] L_SLEEP      = 3'd3;
	localparam logic [LIST_W-1:0] L_DESCHEDULE = 3'd4;
	localparam logic [LIST_W-1:0] L_VANISH     = 3'd5;
	localparam logic [LIST_W-1:0] L_READLINE   = 3'd6;
	localparam logic [LIST_W-1:0] L_BAD        = 3'd7;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_UNLINK, S_DEST, S_RDY_TAIL, S_RDY_CHK, S_RDY_NX,
		S_SLP_HEAD, S_SLP_NX, S_SLP_CHK, S_LB_RD, S_LB_W1, S_LB_W2,
		S_FIND_CHK, S_DONE
	} state_t;

	typedef enum logic [3:0] {
		C_IDLE, C_DECODE, C_UNLINK, C_DEST, C_RDY_TAIL, C_RDY_CHK, C_RDY_NX,
		C_SLP_HEAD, C_SLP_NX, C_SLP_CHK, C_LB_RD, C_LB_W1, C_LB_W2,
		C_FIND_CHK, C_DONE
	} cmd_t;

	typedef struct packed {
		logic is_find;
		logic is_create;
		logic err;
		logic find_empty;
		logic find_hit;
		logic find_wrap;
		logic walk_ready;
		logic walk_sleep;
		logic rdy_match;
		logic rdy_wrap;
		logic slp_ge;
		logic slp_wrap;
		logic lb_empty;
		logic out_free;
	} dp_st_t;

endpackage

FILE: src/tlm_if.sv
// Request and response channel interfaces of the thread list manager.
// Depends on tlm_pkg.
interface tlm_in_if import tlm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [SLOT_W-1:0]   thread_slot;
	logic [PROC_W-1:0]   process_id;
	logic                group_with_process;
	logic [1:0]          target;
	logic [1:0]          wait_reason;
	logic [TIME_W-1:0]   wake_tick;
	logic                reader_front;
	logic [ID_W-1:0]     search_id;

	modport source(output valid, func, thread_slot, process_id, group_with_process,
		target, wait_reason, wake_tick, reader_front, search_id, input ready);
	modport sink(input valid, func, thread_slot, process_id, group_with_process,
		target, wait_reason, wake_tick, reader_front, search_id, output ready);
endinterface

interface tlm_out_if import tlm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STAT_W-1:0]   status;
	logic [SLOT_W-1:0]   result_slot;
	logic [ID_W-1:0]     assigned_id;

	modport source(output valid, status, result_slot, assigned_id, input ready);
	modport sink(input valid, status, result_slot, assigned_id, output ready);
endinterface

FILE: src/tlm_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
module tlm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

FILE: src/tlm_datapath.sv
// Datapath of the thread list manager: list heads, slot tables in RAM,
// walk pointers, result and output registers. Depends on tlm_pkg, tlm_ram.
module tlm_datapath import tlm_pkg::*; #(
	parameter int MAX_THREADS   = TLM_MAX_THREADS,
	parameter int MAX_PROCESSES = TLM_MAX_PROCESSES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	input  logic                in_valid,
	input  logic [FUNC_W-1:0]   func,
	input  logic [SLOT_W-1:0]   thread_slot,
	input  logic [PROC_W-1:0]   process_id,
	input  logic                group_with_process,
	input  logic [1:0]          target,
	input  logic [1:0]          wait_reason,
	input  logic [TIME_W-1:0]   wake_tick,
	input  logic                reader_front,
	input  logic [ID_W-1:0]     search_id,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [STAT_W-1:0]   status,
	output logic [SLOT_W-1:0]   result_slot,
	output logic [ID_W-1:0]     assigned_id,
	output dp_st_t              st
);
	localparam int SW = $clog2(MAX_THREADS);

	// latched request
	logic [FUNC_W-1:0] func_q;
	logic [SLOT_W-1:0] slot_q;
	logic [PROC_W-1:0] proc_q;
	logic              grp_q;
	logic [1:0]        tgt_q;
	logic [TIME_W-1:0] wake_q;
	logic              first_q;
	logic [ID_W-1:0]   sid_q;
	logic [LIST_W-1:0] lst_q;

	// work registers
	logic [LIST_W-1:0] dst_q;
	logic [PROC_W-1:0] sproc_q;
	logic [SW-1:0]     cur_q, hd_q, pos_q, pr_q;
	logic              mh_q;
	logic [STAT_W-1:0] res_stat_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic [ID_W-1:0]   res_id_q;

	// control state
	logic [SW-1:0]          head_q [NUM_LISTS];
	logic [NUM_LISTS-1:0]   ne_q;
	logic [MAX_THREADS-1:0] use_q;
	logic [ID_W-1:0]        next_id_q;
	logic                   o_valid_q;
	logic [STAT_W-1:0]      o_stat_q;
	logic [SLOT_W-1:0]      o_slot_q;
	logic [ID_W-1:0]        o_id_q;

	// RAM ports
	logic [SW-1:0]     ra;
	logic              nx_we, pv_we, li_we, pc_we, id_we, wk_we;
	logic [SW-1:0]     nx_wa, nx_wd, pv_wa, pv_wd;
	logic [SW-1:0]     next_rd, prev_rd;
	logic [LIST_W-1:0] list_rd;
	logic [PROC_W-1:0] proc_rd;
	logic [ID_W-1:0]   ident_rd;
	logic [TIME_W-1:0] wake_rd;
	logic [TIME_W-1:0] wk_wd;

	logic [SW-1:0]     s_c;
	logic [LIST_W-1:0] lst_in, ul_c;
	logic              create_ok, unl_last, unl_head;

	assign s_c    = SW'(slot_q);
	assign lst_in = (target != TGT_WAITING) ? {1'b0, target} : (L_SLEEP + {1'b0, wait_reason});
	assign ul_c   = (list_rd == L_BAD) ? L_READY : list_rd;
	assign unl_head = (head_q[ul_c] == s_c);
	assign unl_last = unl_head && (next_rd == s_c);

	always_comb begin
		st.is_find    = (func_q == FN_FIND);
		st.is_create  = (func_q == FN_CREATE);
		st.err        = (func_q == FN_UNUSED)
			|| (32'(slot_q) >= 32'(MAX_THREADS))
			|| ((func_q == FN_CREATE)
				&& (use_q[s_c] || (32'(proc_q) >= 32'(MAX_PROCESSES))))
			|| ((func_q == FN_MOVE) && !use_q[s_c]);
		st.find_empty = !ne_q[lst_q];
		st.find_hit   = (lst_q == L_VANISH) ? (proc_rd == proc_q) : (ident_rd == sid_q);
		st.find_wrap  = (next_rd == hd_q);
		st.walk_ready = (dst_q == L_READY) && grp_q && ne_q[L_READY];
		st.walk_sleep = (dst_q == L_SLEEP) && ne_q[L_SLEEP];
		st.rdy_match  = (proc_rd == sproc_q);
		st.rdy_wrap   = (prev_rd == hd_q);
		st.slp_ge     = (wake_rd >= wake_q);
		st.slp_wrap   = (next_rd == hd_q);
		st.lb_empty   = !ne_q[dst_q];
		st.out_free   = !o_valid_q || out_ready;
	end

	assign create_ok = st.is_create && !st.err;

	always_comb begin
		ra    = s_c;
		nx_we = 1'b0;
		nx_wa = s_c;
		nx_wd = s_c;
		pv_we = 1'b0;
		pv_wa = s_c;
		pv_wd = s_c;
		li_we = 1'b0;
		pc_we = 1'b0;
		id_we = 1'b0;
		wk_we = 1'b0;
		wk_wd = st.is_create ? '0 : wake_q;
		unique case (cmd)
			C_DECODE: begin
				if (st.is_find)
					ra = head_q[lst_q];
				else if (create_ok) begin
					pc_we = 1'b1;
					id_we = 1'b1;
				end
			end
			C_UNLINK: begin
				if (!unl_last) begin
					pv_we = 1'b1;
					pv_wa = next_rd;
					pv_wd = prev_rd;
					nx_we = 1'b1;
					nx_wa = prev_rd;
					nx_wd = next_rd;
				end
			end
			C_DEST: begin
				li_we = 1'b1;
				wk_we = st.is_create || (tgt_q == TGT_WAITING);
				if (st.walk_ready)
					ra = head_q[L_READY];
				else if (st.walk_sleep)
					ra = head_q[L_SLEEP];
			end
			C_RDY_TAIL: ra = prev_rd;
			C_RDY_CHK:  ra = st.rdy_match ? cur_q : prev_rd;
			C_SLP_HEAD: ra = hd_q;
			C_SLP_NX:   ra = next_rd;
			C_SLP_CHK:  ra = next_rd;
			C_LB_RD: begin
				if (st.lb_empty) begin
					nx_we = 1'b1;
					pv_we = 1'b1;
				end else
					ra = pos_q;
			end
			C_LB_W1: begin
				nx_we = 1'b1;
				nx_wd = pos_q;
				pv_we = 1'b1;
				pv_wd = prev_rd;
			end
			C_LB_W2: begin
				pv_we = 1'b1;
				pv_wa = pos_q;
				nx_we = 1'b1;
				nx_wa = pr_q;
			end
			C_FIND_CHK: ra = next_rd;
			default: ;
		endcase
	end

	tlm_ram #(.WIDTH(SW), .DEPTH(MAX_THREADS)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(ra), .rdata(next_rd));
	tlm_ram #(.WIDTH(SW), .DEPTH(MAX_THREADS)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(ra), .rdata(prev_rd));
	tlm_ram #(.WIDTH(LIST_W), .DEPTH(MAX_THREADS)) u_list (
		.clk(clk), .we(li_we), .waddr(s_c), .wdata(dst_q), .raddr(ra), .rdata(list_rd));
	tlm_ram #(.WIDTH(PROC_W), .DEPTH(MAX_THREADS)) u_proc (
		.clk(clk), .we(pc_we), .waddr(s_c), .wdata(proc_q), .raddr(ra), .rdata(proc_rd));
	tlm_ram #(.WIDTH(ID_W), .DEPTH(MAX_THREADS)) u_ident (
		.clk(clk), .we(id_we), .waddr(s_c), .wdata(next_id_q), .raddr(ra), .rdata(ident_rd));
	tlm_ram #(.WIDTH(TIME_W), .DEPTH(MAX_THREADS)) u_wake (
		.clk(clk), .we(wk_we), .waddr(s_c), .wdata(wk_wd), .raddr(ra), .rdata(wake_rd));

	// list heads, occupancy, id counter, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LISTS; i++)
				head_q[i] <= '0;
			ne_q      <= '0;
			use_q     <= '0;
			next_id_q <= '0;
			o_valid_q <= 1'b0;
		end else begin
			unique case (cmd)
				C_DECODE: begin
					if (!st.is_find && create_ok) begin
						use_q[s_c] <= 1'b1;
						next_id_q  <= next_id_q + 1'b1;
					end
				end
				C_UNLINK: begin
					if (unl_last)
						ne_q[ul_c] <= 1'b0;
					else if (unl_head)
						head_q[ul_c] <= next_rd;
				end
				C_LB_RD: begin
					if (st.lb_empty) begin
						head_q[dst_q] <= s_c;
						ne_q[dst_q]   <= 1'b1;
					end
				end
				C_LB_W2: begin
					if (mh_q)
						head_q[dst_q] <= s_c;
				end
				default: ;
			endcase
			if (cmd == C_DONE && st.out_free)
				o_valid_q <= 1'b1;
			else if (out_ready)
				o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			C_IDLE: begin
				if (in_valid) begin
					func_q  <= func;
					slot_q  <= thread_slot;
					proc_q  <= process_id;
					grp_q   <= group_with_process;
					tgt_q   <= target;
					wake_q  <= wake_tick;
					first_q <= reader_front;
					sid_q   <= search_id;
					lst_q   <= lst_in;
				end
			end
			C_DECODE: begin
				if (st.is_find) begin
					cur_q <= head_q[lst_q];
					hd_q  <= head_q[lst_q];
					res_stat_q <= ST_NOTFOUND;
					res_slot_q <= '0;
					res_id_q   <= '0;
				end else if (st.err) begin
					res_stat_q <= ST_ERROR;
					res_slot_q <= slot_q;
					res_id_q   <= '0;
				end else if (st.is_create) begin
					res_stat_q <= ST_DONE;
					res_slot_q <= slot_q;
					res_id_q   <= next_id_q;
					sproc_q    <= proc_q;
					dst_q      <= L_READY;
				end
			end
			C_UNLINK: begin
				res_stat_q <= ST_DONE;
				res_slot_q <= slot_q;
				res_id_q   <= ident_rd;
				sproc_q    <= proc_rd;
				dst_q      <= lst_q;
				grp_q      <= 1'b1;
			end
			C_DEST: begin
				if (st.walk_sleep) begin
					hd_q  <= head_q[L_SLEEP];
					cur_q <= head_q[L_SLEEP];
				end else if (!st.walk_ready) begin
					pos_q <= head_q[dst_q];
					mh_q  <= (dst_q == L_RUNNING) || ((dst_q == L_READLINE) && first_q);
				end
			end
			C_RDY_TAIL: begin
				hd_q  <= prev_rd;
				cur_q <= prev_rd;
			end
			C_RDY_CHK: begin
				if (!st.rdy_match) begin
					if (st.rdy_wrap) begin
						pos_q <= head_q[L_READY];
						mh_q  <= 1'b0;
					end else
						cur_q <= prev_rd;
				end
			end
			C_RDY_NX: begin
				pos_q <= next_rd;
				mh_q  <= 1'b0;
			end
			C_SLP_HEAD: begin
				pos_q <= hd_q;
				mh_q  <= 1'b1;
			end
			C_SLP_NX: begin
				pos_q <= hd_q;
				mh_q  <= 1'b0;
				cur_q <= next_rd;
			end
			C_SLP_CHK: begin
				mh_q <= 1'b0;
				if (st.slp_ge)
					pos_q <= cur_q;
				else begin
					pos_q <= hd_q;
					cur_q <= next_rd;
				end
			end
			C_LB_W1: pr_q <= prev_rd;
			C_FIND_CHK: begin
				if (st.find_hit) begin
					res_stat_q <= ST_DONE;
					res_slot_q <= SLOT_W'(cur_q);
					res_id_q   <= ident_rd;
				end else
					cur_q <= next_rd;
			end
			C_DONE: begin
				if (st.out_free) begin
					o_stat_q <= res_stat_q;
					o_slot_q <= res_slot_q;
					o_id_q   <= res_id_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = o_valid_q;
	assign status      = o_stat_q;
	assign result_slot = o_slot_q;
	assign assigned_id = o_id_q;
endmodule

FILE: src/tlm_ctrl.sv
// Controller of the thread list manager: sequences decode, unlink,
// placement walks, relink and find. Depends on tlm_pkg.
module tlm_ctrl import tlm_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  dp_st_t st,
	output logic   in_ready,
	output cmd_t   cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:     if (in_valid) state_d = S_DECODE;
			S_DECODE: begin
				priority if (st.is_find)
					state_d = st.find_empty ? S_DONE : S_FIND_CHK;
				else if (st.err)
					state_d = S_DONE;
				else if (st.is_create)
					state_d = S_DEST;
				else
					state_d = S_UNLINK;
			end
			S_UNLINK:   state_d = S_DEST;
			S_DEST: begin
				priority if (st.walk_ready)
					state_d = S_RDY_TAIL;
				else if (st.walk_sleep)
					state_d = S_SLP_HEAD;
				else
					state_d = S_LB_RD;
			end
			S_RDY_TAIL: state_d = S_RDY_CHK;
			S_RDY_CHK: begin
				priority if (st.rdy_match)
					state_d = S_RDY_NX;
				else if (st.rdy_wrap)
					state_d = S_LB_RD;
				else
					state_d = S_RDY_CHK;
			end
			S_RDY_NX:   state_d = S_LB_RD;
			S_SLP_HEAD: state_d = st.slp_ge ? S_LB_RD : S_SLP_NX;
			S_SLP_NX:   state_d = st.slp_wrap ? S_LB_RD : S_SLP_CHK;
			S_SLP_CHK:  state_d = (st.slp_ge || st.slp_wrap) ? S_LB_RD : S_SLP_CHK;
			S_LB_RD:    state_d = st.lb_empty ? S_DONE : S_LB_W1;
			S_LB_W1:    state_d = S_LB_W2;
			S_LB_W2:    state_d = S_DONE;
			S_FIND_CHK: state_d = (st.find_hit || st.find_wrap) ? S_DONE : S_FIND_CHK;
			S_DONE:     if (st.out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE:     cmd = C_IDLE;
			S_DECODE:   cmd = C_DECODE;
			S_UNLINK:   cmd = C_UNLINK;
			S_DEST:     cmd = C_DEST;
			S_RDY_TAIL: cmd = C_RDY_TAIL;
			S_RDY_CHK:  cmd = C_RDY_CHK;
			S_RDY_NX:   cmd = C_RDY_NX;
			S_SLP_HEAD: cmd = C_SLP_HEAD;
			S_SLP_NX:   cmd = C_SLP_NX;
			S_SLP_CHK:  cmd = C_SLP_CHK;
			S_LB_RD:    cmd = C_LB_RD;
			S_LB_W1:    cmd = C_LB_W1;
			S_LB_W2:    cmd = C_LB_W2;
			S_FIND_CHK: cmd = C_FIND_CHK;
			S_DONE:     cmd = C_DONE;
			default:    cmd = C_IDLE;
		endcase
	end
endmodule

FILE: src/thread_state_list_manager.sv
// Thread list manager: one word in flight. An error or an empty find goes from
// decode straight to done; a create adds the destination and placement steps, a
// move also unlink. Ready grouping, sleep insertion and find visit one list entry per cycle.
// The next word is taken in the cycle after the result is registered; a stalled
// result holds the controller.
// Reset clears lists, slot occupancy and the id counter at once; no sweep.
module thread_state_list_manager import tlm_pkg::*; #(
	parameter int MAX_THREADS   = TLM_MAX_THREADS,
	parameter int MAX_PROCESSES = TLM_MAX_PROCESSES
) (
	input logic       clk,
	input logic       arst_n,
	tlm_in_if.sink    req,
	tlm_out_if.source rsp
);
	cmd_t   cmd;
	dp_st_t st;
	logic   in_ready;

	assign req.ready = in_ready;

	tlm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(req.valid), .st(st),
		.in_ready(in_ready), .cmd(cmd));

	tlm_datapath #(.MAX_THREADS(MAX_THREADS), .MAX_PROCESSES(MAX_PROCESSES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_valid(req.valid),
		.func(req.func), .thread_slot(req.thread_slot), .process_id(req.process_id),
		.group_with_process(req.group_with_process), .target(req.target),
		.wait_reason(req.wait_reason), .wake_tick(req.wake_tick),
		.reader_front(req.reader_front), .search_id(req.search_id),
		.out_ready(rsp.ready), .out_valid(rsp.valid), .status(rsp.status),
		.result_slot(rsp.result_slot), .assigned_id(rsp.assigned_id), .st(st));
endmodule

FILE: dv/tb_thread_state_list_manager.sv
// Self-checking bench for thread_state_list_manager: drives create, move and
// find words, predicts each response from a behavioral copy of the lists.
// Depends on tlm_pkg, tlm_if and the RTL top.
module tb_thread_state_list_manager;
	import tlm_pkg::*;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [SLOT_W-1:0] thread_slot;
		logic [PROC_W-1:0] process_id;
		logic              group_with_process;
		logic [1:0]        target;
		logic [1:0]        wait_reason;
		logic [TIME_W-1:0] wake_tick;
		logic              reader_front;
		logic [ID_W-1:0]   search_id;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] result_slot;
		logic [ID_W-1:0]   assigned_id;
	} rsp_t;

	localparam int NSLOT = TLM_MAX_THREADS;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #1 clk = ~clk;

	tlm_in_if  req_if();
	tlm_out_if rsp_if();

	thread_state_list_manager u_dut (
		.clk(clk), .arst_n(arst_n), .req(req_if.sink), .rsp(rsp_if.source)
	);

	// shadow of the block's list state
	logic [SLOT_W-1:0] m_head [NUM_LISTS];
	logic              m_nonempty [NUM_LISTS];
	logic [SLOT_W-1:0] m_next [NSLOT];
	logic [SLOT_W-1:0] m_prev [NSLOT];
	logic              m_used [NSLOT];
	logic [LIST_W-1:0] m_list [NSLOT];
	logic [PROC_W-1:0] m_proc [NSLOT];
	logic [ID_W-1:0]   m_ident [NSLOT];
	logic [TIME_W-1:0] m_wake [NSLOT];
	logic [ID_W-1:0]   m_next_id;

	req_t pending_words[$];
	rsp_t expected_rsp[$];
	int   errors = 0;
	bit   calm = 0;
	int   in_gap = 0;
	int   out_gap = 0;
	int   in_taken = 0;
	int   in_popped = 0;

	task automatic report(input string what, input rsp_t got, input rsp_t exp);
		$display("mismatch %s: got %0d/%0d/%h exp %0d/%0d/%h", what, got.status,
			got.result_slot, got.assigned_id, exp.status, exp.result_slot,
			exp.assigned_id);
		errors++;
	endtask

	task automatic queue_word(input req_t w);
		pending_words.insert(pending_words.size(), w);
	endtask

	function automatic void link_before(input logic [LIST_W-1:0] l,
		input logic [SLOT_W-1:0] s, input logic [SLOT_W-1:0] pos, input bit mk_head);
		logic [SLOT_W-1:0] pr;
		if (!m_nonempty[l]) begin
			m_next[s] = s;
			m_prev[s] = s;
			m_head[l] = s;
			m_nonempty[l] = 1;
			return;
		end
		pr = m_prev[pos];
		m_next[s] = pos;
		m_prev[s] = pr;
		m_prev[pos] = s;
		m_next[pr] = s;
		if (mk_head) m_head[l] = s;
	endfunction

	function automatic void unlink(input logic [LIST_W-1:0] l, input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] nx, pr;
		nx = m_next[s];
		pr = m_prev[s];
		if (m_head[l] == s) begin
			if (nx == s) begin
				m_nonempty[l] = 0;
				return;
			end
			m_head[l] = nx;
		end
		m_prev[nx] = pr;
		m_next[pr] = nx;
	endfunction

	// after the last sibling of the same process, searched from the tail
	function automatic void link_ready(input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] tail, n;
		if (m_nonempty[L_READY]) begin
			tail = m_prev[m_head[L_READY]];
			n = tail;
			for (int k = 0; k < NSLOT; k++) begin
				if (m_proc[n] == m_proc[s]) begin
					link_before(L_READY, s, m_next[n], 0);
					return;
				end
				n = m_prev[n];
				if (n == tail) break;
			end
		end
		link_before(L_READY, s, m_head[L_READY], 0);
	endfunction

	function automatic void link_sleep(input logic [SLOT_W-1:0] s, input logic [TIME_W-1:0] w);
		logic [SLOT_W-1:0] h, n;
		if (!m_nonempty[L_SLEEP]) begin
			link_before(L_SLEEP, s, '0, 1);
			return;
		end
		h = m_head[L_SLEEP];
		if (m_wake[h] >= w) begin
			link_before(L_SLEEP, s, h, 1);
			return;
		end
		n = m_next[h];
		for (int k = 0; k < NSLOT && n != h && m_wake[n] < w; k++)
			n = m_next[n];
		link_before(L_SLEEP, s, n, 0);
	endfunction

	function automatic rsp_t predict_thread_op(input req_t r);
		rsp_t o;
		logic [LIST_W-1:0] lst;
		logic [SLOT_W-1:0] p;
		bit hit;
		lst = (r.target < TGT_WAITING) ? LIST_W'(r.target)
			: L_SLEEP + LIST_W'(r.wait_reason);
		o.status = ST_ERROR;
		o.result_slot = r.thread_slot;
		o.assigned_id = '0;
		if (r.func == FN_FIND) begin
			o.status = ST_NOTFOUND;
			o.result_slot = '0;
			if (m_nonempty[lst]) begin
				p = m_head[lst];
				for (int k = 0; k < NSLOT; k++) begin
					hit = (lst == L_VANISH) ? (m_proc[p] == r.process_id)
						: (m_ident[p] == r.search_id);
					if (hit) begin
						o.status = ST_DONE;
						o.result_slot = p;
						o.assigned_id = m_ident[p];
						break;
					end
					p = m_next[p];
					if (p == m_head[lst]) break;
				end
			end
			return o;
		end
		if (r.func == FN_UNUSED) return o;
		if (r.func == FN_CREATE) begin
			if (m_used[r.thread_slot]) return o;
			m_used[r.thread_slot] = 1;
			m_ident[r.thread_slot] = m_next_id;
			m_next_id++;
			m_proc[r.thread_slot] = r.process_id;
			m_wake[r.thread_slot] = '0;
			m_list[r.thread_slot] = L_READY;
			if (r.group_with_process) link_ready(r.thread_slot);
			else link_before(L_READY, r.thread_slot, m_head[L_READY], 0);
			o.status = ST_DONE;
			o.assigned_id = m_ident[r.thread_slot];
			return o;
		end
		if (!m_used[r.thread_slot]) return o;
		unlink(m_list[r.thread_slot], r.thread_slot);
		case (lst)
			L_READY: link_ready(r.thread_slot);
			L_RUNNING: link_before(L_RUNNING, r.thread_slot, m_head[L_RUNNING], 1);
			L_SLEEP: link_sleep(r.thread_slot, r.wake_tick);
			L_READLINE: link_before(L_READLINE, r.thread_slot, m_head[L_READLINE],
				r.reader_front);
			default: link_before(lst, r.thread_slot, m_head[lst], 0);
		endcase
		if (r.target == TGT_WAITING) m_wake[r.thread_slot] = r.wake_tick;
		m_list[r.thread_slot] = lst;
		o.status = ST_DONE;
		o.assigned_id = m_ident[r.thread_slot];
		return o;
	endfunction

	function automatic req_t rand_word(input logic [FUNC_W-1:0] f);
		req_t r;
		r.func = f;
		r.thread_slot = SLOT_W'($urandom_range(0, 63));
		r.process_id = ($urandom_range(0, 3) == 0) ? PROC_W'($urandom_range(0, 63))
			: PROC_W'($urandom_range(0, 5));
		r.group_with_process = 1'($urandom);
		r.target = 2'($urandom);
		r.wait_reason = 2'($urandom);
		case ($urandom_range(0, 3))
			0: r.wake_tick = $urandom;
			1: r.wake_tick = $urandom_range(0, 8);
			2: r.wake_tick = 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: r.wake_tick = $urandom_range(0, 1000);
		endcase
		r.reader_front = 1'($urandom);
		// mostly ids that exist, sometimes any value
		r.search_id = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 70);
		return r;
	endfunction

	// driver
	always @(negedge clk) begin
		bit took;
		if (arst_n) begin
			took = (in_taken != in_popped);
			if (took) begin
				pending_words.delete(0);
				in_popped++;
			end
			if (req_if.valid && !took) begin
				// hold word until accepted
			end else if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				req_if.valid <= 1'b0;
			end else if (pending_words.size() > 0) begin
				if (!calm && $urandom_range(0, 5) == 0) begin
					in_gap <= $urandom_range(0, 2);
					req_if.valid <= 1'b0;
				end else begin
					req_if.valid <= 1'b1;
					{req_if.func, req_if.thread_slot, req_if.process_id,
						req_if.group_with_process, req_if.target, req_if.wait_reason,
						req_if.wake_tick, req_if.reader_front, req_if.search_id}
						<= pending_words[0];
				end
			end else begin
				req_if.valid <= 1'b0;
			end
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				rsp_if.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_gap <= $urandom_range(0, 2);
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		req_t r;
		rsp_t got, exp;
		if (arst_n) begin
			if (req_if.valid && req_if.ready) begin
				r = {req_if.func, req_if.thread_slot, req_if.process_id,
					req_if.group_with_process, req_if.target, req_if.wait_reason,
					req_if.wake_tick, req_if.reader_front, req_if.search_id};
				expected_rsp.insert(expected_rsp.size(), predict_thread_op(r));
				in_taken++;
			end
			if (rsp_if.valid && rsp_if.ready) begin
				got = {rsp_if.status, rsp_if.result_slot, rsp_if.assigned_id};
				if (expected_rsp.size() == 0) begin
					report("unexpected word", got, got);
				end else begin
					exp = expected_rsp[0];
					expected_rsp.delete(0);
					if (got.status !== exp.status) report("status", got, exp);
					if (got.result_slot !== exp.result_slot) report("result_slot", got, exp);
					if (got.assigned_id !== exp.assigned_id) report("assigned_id", got, exp);
				end
			end
		end
	end

	initial begin
		req_t r;
		int n;
		req_if.valid = 1'b0;
		{req_if.func, req_if.thread_slot, req_if.process_id, req_if.group_with_process,
			req_if.target, req_if.wait_reason, req_if.wake_tick, req_if.reader_front,
			req_if.search_id} = '0;
		rsp_if.ready = 1'b0;
		for (int i = 0; i < NUM_LISTS; i++) begin
			m_head[i] = '0;
			m_nonempty[i] = 0;
		end
		for (int i = 0; i < NSLOT; i++) begin
			m_used[i] = 0;
			m_next[i] = '0; m_prev[i] = '0; m_list[i] = '0;
			m_proc[i] = '0; m_ident[i] = '0; m_wake[i] = '0;
		end
		m_next_id = '0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: empty finds, move of free slot, unused code, creates at extremes
		r = rand_word(FN_FIND); r.target = 2'd0; r.search_id = '0; queue_word(r);
		r = rand_word(FN_FIND); r.target = 2'd3; r.wait_reason = 2'd2; queue_word(r);
		r = rand_word(FN_MOVE); r.thread_slot = 6'd5; queue_word(r);
		r = rand_word(FN_UNUSED); queue_word(r);
		r = rand_word(FN_CREATE); r.thread_slot = 6'd0; r.process_id = 6'd0; queue_word(r);
		r = rand_word(FN_CREATE); r.thread_slot = 6'd63; r.process_id = 6'd63;
		r.group_with_process = 1'b1; queue_word(r);
		r = rand_word(FN_CREATE); r.thread_slot = 6'd0; queue_word(r);
		r = rand_word(FN_CREATE); r.thread_slot = 6'd1; r.process_id = 6'd0;
		r.group_with_process = 1'b1; queue_word(r);
		r = rand_word(FN_CREATE); r.thread_slot = 6'd2; r.process_id = 6'd63;
		r.group_with_process = 1'b1; queue_word(r);
		// every destination, self-reference on a single-entry list
		for (int t = 0; t < 7; t++) begin
			r = rand_word(FN_MOVE); r.thread_slot = SLOT_W'((t % 2) ? 63 : 0);
			r.target = 2'((t < 3) ? t : 3); r.wait_reason = 2'((t < 3) ? 0 : t - 3);
			r.wake_tick = (t == 3) ? 32'hFFFF_FFFF : '0; r.reader_front = t[0];
			queue_word(r);
		end
		r = rand_word(FN_MOVE); r.thread_slot = 6'd1; r.target = 2'd3; r.wait_reason = 2'd0;
		r.wake_tick = '0; queue_word(r);
		r = rand_word(FN_MOVE); r.thread_slot = 6'd0; r.target = 2'd0; queue_word(r);
		r = rand_word(FN_FIND); r.target = 2'd0; r.search_id = '0; queue_word(r);
		r = rand_word(FN_FIND); r.target = 2'd3; r.wait_reason = 2'd0; r.search_id = 32'd1;
		queue_word(r);
		r = rand_word(FN_FIND); r.target = 2'd3; r.wait_reason = 2'd2; r.process_id = 6'd63;
		queue_word(r);
		r = rand_word(FN_FIND); r.target = 2'd1; r.search_id = 32'hFFFF_FFFF;
		queue_word(r);

		// random: mostly moves and finds, some creates, rare unused codes
		n = 0;
		while (n < 1750) begin
			if (pending_words.size() > 8) begin
				@(negedge clk);
				continue;
			end
			if (n > 1500) calm = 1;
			case ($urandom_range(0, 9))
				0, 1: r = rand_word(FN_CREATE);
				2, 3, 4, 5: r = rand_word(FN_MOVE);
				6, 7, 8: r = rand_word(FN_FIND);
				default: r = rand_word(FN_FIND);
			endcase
			if ($urandom_range(0, 60) == 0) r.func = FN_UNUSED;
			queue_word(r);
			n++;
		end
		wait (pending_words.size() == 0 && !req_if.valid);
		wait (expected_rsp.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("PASS thread_state_list_manager");
		end else begin
			$display("FAIL thread_state_list_manager");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("FAIL thread_state_list_manager");
		$finish;
	end

endmodule
